// ===== design/swa_pkg.sv =====
package swa_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // fraction bits of the average
    localparam int FRAC_BITS = 8;

    // width of the window_len input and of the reported fill count
    localparam int WIN_REG_BITS = 7;
    localparam int CNT_OUT_BITS = 7;

    localparam int DEF_CNT_W = $clog2(DEF_MAX_WINDOW + 1);
    localparam int DEF_SUM_W = DEF_SAMPLE_BITS + $clog2(DEF_MAX_WINDOW);
    localparam int DEF_AVG_W = DEF_SAMPLE_BITS + FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DIV  = 3'b100
    } swa_state_t;

endpackage

// ===== design/sliding_window_average.sv =====
// Flow from accepted sample to out_valid: one ring read, one sum update, then a bit-serial
// divide whose result is registered into the output when out_stall allows.
// Only one sample is in flight: a new sample is not accepted until the result is taken,
// which waits on the restoring divider (one quotient bit per cycle) and on out_stall.
// Reset: window length 1, empty window, no result pending; ring contents are not cleared
// and are only read back after being rewritten in the current fill.
module sliding_window_average #(
    parameter int MAX_WINDOW  = swa_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [swa_pkg::WIN_REG_BITS-1:0]          window_len,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [SAMPLE_BITS+swa_pkg::FRAC_BITS-1:0] average_q8,
    output logic [swa_pkg::CNT_OUT_BITS-1:0]          samples_in_window
);

    import swa_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;

    swa_state_t state_reg, state_next;

    logic [CNT_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic                    out_valid_reg, out_valid_next;
    logic signed [AVG_W-1:0] avg_reg;
    logic [CNT_OUT_BITS-1:0] cnt_out_reg;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] old_rd_reg;

    logic                    in_take;
    logic                    ring_rd;
    logic                    ring_wr;
    logic                    full;
    logic [CNT_W-1:0]        ptr_inc;
    logic [CNT_W-1:0]        win_clamped;
    logic signed [SUM_W-1:0] sum_upd;
    logic                    out_free;
    logic                    div_done;
    logic                    div_take;
    logic signed [AVG_W-1:0] div_quo;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign div_take = (state_reg == ST_DIV) && div_done && out_free;

    // read the outgoing sample as the item is accepted, write the new one in ST_READ
    assign ring_rd = in_take;
    assign ring_wr = (state_reg == ST_READ);

    always_comb
    begin
        if (window_len == '0)
            win_clamped = CNT_W'(1);
        else if (int'(window_len) > MAX_WINDOW)
            win_clamped = CNT_W'(MAX_WINDOW);
        else
            win_clamped = CNT_W'(window_len);
    end

    assign full    = (cnt_reg >= win_reg);
    assign ptr_inc = CNT_W'(ptr_reg) + CNT_W'(1);
    assign sum_upd = sum_reg - (full ? SUM_W'(old_rd_reg) : SUM_W'(0)) + SUM_W'(sample_reg);

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    // restart the window empty
                    win_next = win_clamped;
                    cnt_next = '0;
                    ptr_next = '0;
                    sum_next = '0;
                end
                if (in_take)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                sum_next   = sum_upd;
                cnt_next   = full ? win_reg : (cnt_reg + 1'b1);
                ptr_next   = (ptr_inc >= win_reg) ? '0 : ptr_inc[PTR_W-1:0];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_take)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= CNT_W'(1);
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= sample;
        if (div_take)
        begin
            avg_reg     <= div_quo;
            cnt_out_reg <= CNT_OUT_BITS'(cnt_reg);
        end
    end

    // one item at a time: a read never overlaps the write of the same entry
    always_ff @(posedge clk)
    begin
        if (ring_rd)
            old_rd_reg <= ring_mem[ptr_reg];
        if (ring_wr)
            ring_mem[ptr_reg] <= sample_reg;
    end

    swa_div #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W),
        .QUO_W (AVG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_READ),
        .dividend (sum_upd),
        .divisor  (full ? win_reg : (cnt_reg + 1'b1)),
        .take     (div_take),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid         = out_valid_reg;
    assign average_q8        = avg_reg;
    assign samples_in_window = cnt_out_reg;

endmodule

// ===== design/swa_div.sv =====
module swa_div #(
    parameter int SUM_W = swa_pkg::DEF_SUM_W,
    parameter int DIV_W = swa_pkg::DEF_CNT_W,
    parameter int QUO_W = swa_pkg::DEF_AVG_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [DIV_W-1:0] divisor,
    input  logic                    take,
    output logic                    done,
    output logic signed [QUO_W-1:0] quotient
);

    import swa_pkg::*;

    localparam int DVD_W = SUM_W + FRAC_BITS;
    localparam int CYC_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CYC_W-1:0] cyc_reg, cyc_next;
    logic             neg_reg, neg_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DVD_W-1:0] dq_reg, dq_next;

    logic [SUM_W-1:0] dvd_mag;
    logic [DIV_W:0]   rem_shift;
    logic             rem_ge;
    logic [QUO_W-1:0] quo_mag;

    // magnitude of the dividend; the most negative sum still fits unsigned
    assign dvd_mag = dividend[SUM_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg[DIV_W-1:0], dq_reg[DVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cyc_next  = cyc_reg;
        neg_next  = neg_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cyc_next  = CYC_W'(DVD_W);
            neg_next  = dividend[SUM_W-1];
            div_next  = divisor;
            rem_next  = '0;
            dq_next   = {dvd_mag, {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = rem_ge ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            dq_next  = {dq_reg[DVD_W-2:0], rem_ge};
            cyc_next = cyc_reg - 1'b1;
            if (cyc_reg == CYC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (take)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cyc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cyc_reg  <= cyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    // quotient magnitude always fits QUO_W bits; restore the sign (toward zero)
    assign quo_mag  = dq_reg[QUO_W-1:0];
    assign quotient = neg_reg ? $signed(~quo_mag + 1'b1) : $signed(quo_mag);
    assign done     = done_reg;

endmodule

// ===== design/swa_checker.sv =====
module swa_checker #(
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input logic                                              clk,
    input logic                                              rst_n,
    input logic                                              in_valid,
    input logic                                              in_stall,
    input logic signed [SAMPLE_BITS-1:0]                     sample,
    input logic                                              out_valid,
    input logic                                              out_stall,
    input logic signed [SAMPLE_BITS+swa_pkg::FRAC_BITS-1:0]  average_q8,
    input logic [swa_pkg::CNT_OUT_BITS-1:0]                  samples_in_window
);

    import swa_pkg::*;

    // one sample in flight: an accepted transaction closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a sample is in flight");

    // a new result only appears as the input side reopens
    a_result_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result appeared without a sample in flight");

    // every result covers at least one sample
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_in_window != '0)
        else $error("result reports an empty window");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average_q8)
                                   && $stable(samples_in_window))
        else $error("stalled result transaction changed");

    // hold a stalled input transaction as offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(sample))
        else $error("stalled input transaction changed");

endmodule

bind sliding_window_average swa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .sample            (sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .average_q8        (average_q8),
    .samples_in_window (samples_in_window)
);

// ===== dv/tb_top.sv =====
module tb_top;

    import swa_pkg::*;

    localparam int SW          = DEF_SAMPLE_BITS;
    localparam int AW          = DEF_AVG_W;
    localparam int MAX_WIN     = DEF_MAX_WINDOW;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 13;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_AT     = N_DIRECTED + 3 * PHASE_ITEMS + 20;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic signed [AW-1:0]       avg;
        logic [CNT_OUT_BITS-1:0]    cnt;
    } window_result_t;

    typedef struct packed {
        logic                       do_cfg;
        logic [WIN_REG_BITS-1:0]    cfg_val;
        logic signed [SW-1:0]       smp;
        logic                       typed;
        logic signed [AW-1:0]       avg;
        logic [CNT_OUT_BITS-1:0]    cnt;
    } directed_row_t;

    typedef enum int { PAT_MIX, PAT_ALL_MAX, PAT_ALL_MIN } sample_pattern_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [WIN_REG_BITS-1:0]        window_len = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic signed [SW-1:0]           sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [AW-1:0]           average_q8;
    logic [CNT_OUT_BITS-1:0]        samples_in_window;

    // hand-computed expectation travels with the sample it belongs to
    logic                           typed_flag = 1'b0;
    window_result_t                 typed_res = '0;

    int                             src_idle_pct = 0;
    int                             sink_stall_pct = 0;
    int                             samples_taken = 0;
    int                             stuck_cycles = 0;
    int                             errors = 0;

    window_result_t                 pending_averages[$];

    // shadow of the filter state
    logic [WIN_REG_BITS-1:0]        win_reg = 7'd1;
    logic signed [SW-1:0]           ring [MAX_WIN];
    int unsigned                    wpos = 0;
    int unsigned                    fill = 0;
    longint                         run_sum = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, 7'd0,   16'sh7fff,  1'b1, 24'sd8388352,  7'd1},
        '{1'b0, 7'd0,   16'sh8000,  1'b1, 24'sh800000,   7'd1},
        '{1'b0, 7'd0,   16'sd0,     1'b1, 24'sd0,        7'd1},
        '{1'b0, 7'd0,   -16'sd1,    1'b1, -24'sd256,     7'd1},
        '{1'b1, 7'd0,   16'sd5,     1'b1, 24'sd1280,     7'd1},
        '{1'b0, 7'd0,   16'sd7,     1'b1, 24'sd1792,     7'd1},
        '{1'b1, 7'd127, 16'sh7fff,  1'b1, 24'sd8388352,  7'd1},
        '{1'b0, 7'd0,   16'sh8000,  1'b1, -24'sd128,     7'd2},
        '{1'b0, 7'd0,   16'sd100,   1'b0, 24'sd0,        7'd0},
        '{1'b1, 7'd3,   16'sd1,     1'b1, 24'sd256,      7'd1},
        '{1'b0, 7'd0,   16'sd2,     1'b1, 24'sd384,      7'd2},
        '{1'b0, 7'd0,   16'sd4,     1'b0, 24'sd0,        7'd0},
        '{1'b0, 7'd0,   16'sd8,     1'b0, 24'sd0,        7'd0},
        '{1'b0, 7'd0,   16'sd16,    1'b0, 24'sd0,        7'd0},
        '{1'b1, 7'd3,   -16'sd1,    1'b1, -24'sd256,     7'd1},
        '{1'b0, 7'd0,   16'sd0,     1'b1, -24'sd128,     7'd2},
        '{1'b0, 7'd0,   16'sd0,     1'b1, -24'sd85,      7'd3},
        '{1'b0, 7'd0,   16'sd0,     1'b1, 24'sd0,        7'd3},
        '{1'b1, 7'd2,   16'sh8000,  1'b1, 24'sh800000,   7'd1},
        '{1'b0, 7'd0,   16'sh8000,  1'b1, 24'sh800000,   7'd2},
        '{1'b0, 7'd0,   16'sh7fff,  1'b1, -24'sd128,     7'd2},
        '{1'b1, 7'd64,  16'sd12345, 1'b0, 24'sd0,        7'd0},
        '{1'b0, 7'd0,   -16'sd7,    1'b0, 24'sd0,        7'd0},
        '{1'b1, 7'd65,  16'sd9,     1'b0, 24'sd0,        7'd0},
        '{1'b1, 7'd1,   16'sh8000,  1'b1, 24'sh800000,   7'd1}
    };

    logic [WIN_REG_BITS-1:0] phase_win [N_PHASES] = '{
        7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd5,
        7'd10, 7'd64, 7'd64, 7'd16, 7'd20
    };

    sliding_window_average dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .window_len        (window_len),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .average_q8        (average_q8),
        .samples_in_window (samples_in_window)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_window();
        if (win_reg < 1)
            return 1;
        if (win_reg > MAX_WIN)
            return MAX_WIN;
        return win_reg;
    endfunction

    task automatic advance_window(input logic signed [SW-1:0] s, output window_result_t r);
        int unsigned w;
        longint      scaled;
        w = eff_window();
        if (wpos >= w)
            wpos = 0;
        // full window: drop the oldest sample before adding the new one
        if (fill >= w)
        begin
            run_sum -= ring[wpos];
            fill = w;
        end
        else
            fill++;
        ring[wpos] = s;
        run_sum += s;
        wpos++;
        if (wpos >= w)
            wpos = 0;
        scaled = (run_sum * 256) / longint'(fill);
        r.avg = scaled[AW-1:0];
        r.cnt = fill[CNT_OUT_BITS-1:0];
    endtask

    function automatic logic signed [SW-1:0] pick_sample(sample_pattern_t pat);
        int r;
        case (pat)
            PAT_ALL_MAX: return 16'sh7fff;
            PAT_ALL_MIN: return 16'sh8000;
            default:
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    return 16'sh7fff;
                if (r == 1)
                    return 16'sh8000;
                if (r == 2)
                    return 16'($urandom_range(0, 8)) - 16'd4;
                return 16'($urandom());
            end
        endcase
    endfunction

    // check results first so a result never pairs with a sample taken in the same cycle
    always @(posedge clk)
    begin : scoreboard
        window_result_t want;
        logic           in_acc;
        logic           out_acc;
        if (rst_n)
        begin
            in_acc  = in_valid && !in_stall;
            out_acc = out_valid && !out_stall;
            if (out_acc)
            begin
                if (pending_averages.size() == 0)
                begin
                    $display("%0t: unexpected result average_q8=%0d samples_in_window=%0d",
                             $time, average_q8, samples_in_window);
                    errors++;
                end
                else
                begin
                    want = pending_averages.pop_front();
                    if (average_q8 !== want.avg)
                    begin
                        $display("%0t: average_q8 expected %0d, got %0d",
                                 $time, $signed(want.avg), average_q8);
                        errors++;
                    end
                    if (samples_in_window !== want.cnt)
                    begin
                        $display("%0t: samples_in_window expected %0d, got %0d",
                                 $time, want.cnt, samples_in_window);
                        errors++;
                    end
                end
            end
            if (in_acc)
            begin
                advance_window(sample, want);
                if (typed_flag)
                    want = typed_res;
                pending_averages.push_back(want);
                samples_taken++;
            end
            if (in_acc || out_acc)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("** sliding_window_average: FAILED **");
        $finish;
    end

    // output side: random stall plus one long hold once the stream is well underway
    initial
    begin : sink_proc
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && samples_taken >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic drive_sample(input logic signed [SW-1:0] s, input logic typed,
                                input window_result_t t);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= s;
        typed_flag <= typed;
        typed_res  <= t;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_window(input logic [WIN_REG_BITS-1:0] v);
        wait_drained();
        cfg_we     <= 1'b1;
        window_len <= v;
        @(negedge clk);
        cfg_we  <= 1'b0;
        win_reg = v;
        wpos    = 0;
        fill    = 0;
        run_sum = 0;
    endtask

    initial
    begin : stimulus
        window_result_t  t;
        directed_row_t   row;
        sample_pattern_t pat;
        logic [WIN_REG_BITS-1:0] w;

        for (int i = 0; i < MAX_WIN; i++)
            ring[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            if (row.do_cfg)
                write_window(row.cfg_val);
            t.avg = row.avg;
            t.cnt = row.cnt;
            drive_sample(row.smp, row.typed, t);
        end

        t = '0;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            w = phase_win[ph];
            if (ph == 8 || ph == 12)
                w = 7'($urandom_range(2, 127));
            write_window(w);
            case (ph % 4)
                0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct <= 84; sink_stall_pct <= 0;  end
                2: begin src_idle_pct <= 0;  sink_stall_pct <= 84; end
                default: begin src_idle_pct <= 31; sink_stall_pct <= 31; end
            endcase
            pat = (ph == 9) ? PAT_ALL_MAX : (ph == 10) ? PAT_ALL_MIN : PAT_MIX;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (ph == 5 && k == 60)
                    wait_drained();
                drive_sample(pick_sample(pat), 1'b0, t);
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("** sliding_window_average: PASSED **");
        else
            $display("** sliding_window_average: FAILED **");
        $finish;
    end

endmodule
